// File: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// ASSERT_CLK expects the enclosing module to have i_clk and i_rst_n; ASSERT_RST needs only i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/mma_pkg.sv
package mma_pkg;

    // Field widths of the ports
    localparam int CHAN_W   = 1;
    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;

    // Default configuration
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_WINDOW      = 16;
    localparam int DEF_SAMPLE_BITS = 12;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_LOAD,
        S_DIV,
        S_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mem_read;
        logic update;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_range;
    } t_status;

endpackage

// File: sv/mma_ctrl.sv
`include "assert_macros.svh"

module mma_ctrl #(
    parameter int SAMPLE_BITS = mma_pkg::DEF_SAMPLE_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mma_pkg::t_status i_status,
    output mma_pkg::t_cmd   o_cmd
);
    import mma_pkg::*;

    localparam int SW    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CNT_W = $clog2(SW);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic               out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_READ;
            S_READ:   n_state = i_status.in_range ? S_UPDATE : S_RESULT;
            S_UPDATE: n_state = S_LOAD;
            S_LOAD:   n_state = S_DIV;
            S_DIV:    if (r_cnt == '0) n_state = S_RESULT;
            S_RESULT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_READ:   o_cmd.mem_read = i_status.in_range;
            S_UPDATE: o_cmd.update   = 1'b1;
            S_LOAD:   o_cmd.div_load = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_RESULT: o_cmd.out_load = out_free;
            default:  o_cmd          = '0;
        endcase
    end

    // State, divider step counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.div_load) begin
                r_cnt <= CNT_W'(SW - 1);
            end else if (o_cmd.div_step) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_RST(a_rst_idle, !i_rst_n |=> (o_in_ready && !o_out_valid), "not idle after reset")
    `ASSERT_CLK(a_result_frees, o_cmd.out_load |=> (o_in_ready && o_out_valid), "result lost")
    `ASSERT_CLK(a_div_start, (r_state == S_LOAD) |=> (o_cmd.div_step && (r_cnt == CNT_W'(SW - 1))), "divider start")

endmodule

// File: sv/mma_div.sv
`include "assert_macros.svh"

module mma_div #(
    parameter int QUO_W = mma_pkg::SAMPLE_W,
    parameter int DIV_W = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_step,
    input  logic [DIV_W+QUO_W-1:0]   i_dividend,
    input  logic [DIV_W-1:0]         i_divisor,
    output logic [QUO_W-1:0]         o_quotient
);
    import mma_pkg::*;

    // Restoring divider, one quotient bit a cycle while i_step is high.
    // The dividend is below divisor << QUO_W, so the upper part starts the remainder.
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [QUO_W-1:0]  r_quo;
    logic [DIV_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_dividend[DIV_W+QUO_W-1:QUO_W];
            r_quo <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
        end else if (i_step) begin
            r_rem <= ge ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;

    `ASSERT_CLK(a_rem_bound, i_step |-> (r_rem < r_div), "remainder not below divisor")

endmodule

// File: sv/mma_dp.sv
`include "assert_macros.svh"

module mma_dp #(
    parameter int CHANNELS    = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW      = mma_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = mma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mma_pkg::t_cmd                 i_cmd,
    output mma_pkg::t_status              o_status,
    input  logic [mma_pkg::CHAN_W-1:0]    i_channel,
    input  logic [mma_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [mma_pkg::CHAN_W-1:0]    o_channel_out,
    output logic [mma_pkg::AVG_W-1:0]     o_average
);
    import mma_pkg::*;

    localparam int SW     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int FC_W   = $clog2(WINDOW + 1);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W  = SW + FC_W;
    localparam int ADDR_W = CH_W + POS_W;
    localparam int DEPTH  = CHANNELS * (2 ** POS_W);

    // Captured item
    logic [CHAN_W-1:0]  r_chan;
    logic [SW-1:0]      r_sample;

    // Per-channel state
    logic [SUM_W-1:0]   r_sum  [CHANNELS];
    logic [FC_W-1:0]    r_fill [CHANNELS];
    logic [POS_W-1:0]   r_pos  [CHANNELS];

    // Sample rings, one row per channel
    logic [SW-1:0]      r_mem [DEPTH];
    logic [SW-1:0]      r_rd_data;

    // Result register
    logic [CHAN_W-1:0]  r_chan_out;
    logic [AVG_W-1:0]   r_avg;

    logic               in_range;
    logic [CH_W-1:0]    ch_idx;
    logic [POS_W-1:0]   cur_pos;
    logic [ADDR_W-1:0]  addr;
    logic               full;
    logic [SUM_W-1:0]   n_sum;
    logic [SW-1:0]      quotient;

    // Channel decode
    assign in_range = (CHANNELS > 1) || (r_chan == 1'b0);
    assign ch_idx   = in_range ? CH_W'(r_chan) : '0;
    assign cur_pos  = r_pos[ch_idx];
    assign addr     = {ch_idx, cur_pos};
    assign full     = r_fill[ch_idx] == FC_W'(WINDOW);
    assign o_status.in_range = in_range;

    // Drop the oldest sample once the ring is full, add the new one
    assign n_sum = r_sum[ch_idx] - (full ? SUM_W'(r_rd_data) : '0) + SUM_W'(r_sample);

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_chan   <= i_channel;
            r_sample <= i_sample[SW-1:0];
        end
    end

    // Ring storage: registered read, one write
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd_data <= r_mem[addr];
        end
        if (i_cmd.update) begin
            r_mem[addr] <= r_sample;
        end
    end

    // Running sum, fill count, write position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]  <= '0;
                r_fill[c] <= '0;
                r_pos[c]  <= '0;
            end
        end else if (i_cmd.update) begin
            r_sum[ch_idx] <= n_sum;
            if (!full) begin
                r_fill[ch_idx] <= r_fill[ch_idx] + 1'b1;
            end
            r_pos[ch_idx] <= (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
        end
    end

    // Sum / fill count
    mma_div #(
        .QUO_W (SW),
        .DIV_W (FC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum[ch_idx]),
        .i_divisor  (r_fill[ch_idx]),
        .o_quotient (quotient)
    );

    // Result register; unknown channel gives zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_chan_out <= r_chan;
            r_avg      <= in_range ? AVG_W'(quotient) : '0;
        end
    end

    assign o_channel_out = r_chan_out;
    assign o_average     = r_avg;

    `ASSERT_CLK(a_sum_bound, i_cmd.update |=> (r_sum[ch_idx] < (SUM_W'(r_fill[ch_idx]) << SW)), "sum exceeds fill range")

endmodule

// File: sv/multichannel_moving_average_core.sv
// Per-channel simple moving average. Each transfer on the input carries a channel number and
// an ADC sample; each produces exactly one result transfer with the channel and the truncated
// mean of that channel's last WINDOW samples (the mean of all samples so far during warm-up).
// An unknown channel leaves the state alone and returns an average of zero. From acceptance
// to result a sample passes through capture, ring read, state update, divider load, one step
// per quotient bit in the shift-subtract divider, and the load of the output register; an
// unknown channel skips the update and the divider. The output register lets the next sample
// be taken while a result still waits.
module multichannel_moving_average_core #(
    parameter int CHANNELS    = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW      = mma_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = mma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mma_pkg::CHAN_W-1:0]    i_channel,
    input  logic [mma_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mma_pkg::CHAN_W-1:0]    o_channel_out,
    output logic [mma_pkg::AVG_W-1:0]     o_average
);
    import mma_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    mma_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Rings, sums and divider
    mma_dp #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_channel_out (o_channel_out),
        .o_average     (o_average)
    );

endmodule
